### sv/abl_pkg.sv
// shared types, codes and constants of the argb blend pipeline
package abl_pkg;

    // blend mode codes
    localparam logic [2:0] MODE_ARGB_OVER_ARGB = 3'd0;
    localparam logic [2:0] MODE_RGB_OVER_ARGB  = 3'd1;
    localparam logic [2:0] MODE_ARGB_OVER_RGB  = 3'd2;
    localparam logic [2:0] MODE_TRANS_KEEP     = 3'd3;
    localparam logic [2:0] MODE_ADD_ALPHA      = 3'd4;

    // configuration register indexes
    localparam logic CFG_IDX_MODE   = 1'b0;
    localparam logic CFG_IDX_GALPHA = 1'b1;

    // channel masks
    localparam logic [31:0] MASK_A    = 32'hFF00_0000;
    localparam logic [23:0] MASK_RB24 = 24'hFF_00FF;
    localparam logic [15:0] MASK_G16  = 16'hFF00;

    // reciprocal table: entry k holds 0x10000 / (k + 1)
    localparam int RECIP_W     = 17;
    localparam int RECIP_DEPTH = 256;
    localparam int RECIP_NUM   = 32'h0001_0000;

    // how the last stage builds the result word
    typedef enum logic [1:0] {
        K_PASS,
        K_OVER,
        K_LERP_NO_A,
        K_LERP_KEEP_A
    } t_kind;

    // after operand prep
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] pass;
        logic [7:0]  src_r;
        logic [7:0]  src_g;
        logic [7:0]  src_b;
        logic [23:0] base_rb;
        logic [15:0] base_g;
        logic [8:0]  f;
        logic [8:0]  da;
        logic [7:0]  dst_a;
    } t_prep;

    // after the blend step
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] pass;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [8:0]  fa;
        logic [7:0]  dst_a;
    } t_mix;

    // after reciprocal lookup
    typedef struct packed {
        t_mix               m;
        logic [RECIP_W-1:0] recip;
    } t_rcp;

endpackage

### sv/argb_pixel_alpha_blend.sv
// top level of the argb pixel blender: config registers and four-stage pipeline
// a result strobes once its request has passed the prep, mix, recip and norm registers, one per request
// throughput: one request per clock; busy stays low, the pipeline never stalls
// the receiver cannot stall, so each result is shown for exactly one cycle
// reset clears the mode and global alpha to zero and drops all requests in flight
// the pipeline depth is set by the renormalize path: blend, table lookup, multiply
module argb_pixel_alpha_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic [31:0] i_src_pixel,
    input  logic [31:0] i_dst_pixel,
    output logic        o_strobe,
    output logic [31:0] o_result_pixel
);
    import abl_pkg::*;

    logic [2:0]  r_blend_mode;
    logic [7:0]  r_global_alpha;
    logic        accept;
    t_prep       s_prep;
    t_mix        s_mix;
    t_rcp        s_rcp;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode   <= MODE_ARGB_OVER_ARGB;
            r_global_alpha <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_MODE:   r_blend_mode   <= i_cfg_wdata[2:0];
                CFG_IDX_GALPHA: r_global_alpha <= i_cfg_wdata;
            endcase
        end
    end

    // pipeline stages
    abl_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_mode   (r_blend_mode),
        .i_galpha (r_global_alpha),
        .i_src    (i_src_pixel),
        .i_dst    (i_dst_pixel),
        .o_s      (s_prep)
    );

    abl_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s     (s_prep),
        .o_s     (s_mix)
    );

    abl_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s     (s_mix),
        .o_s     (s_rcp)
    );

    abl_norm u_norm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s            (s_rcp),
        .o_strobe       (o_strobe),
        .o_result_pixel (o_result_pixel)
    );

`ifndef ASSERT_OFF
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_strobe)
        else $error("request did not produce a result four cycles later");

    a_result_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 4))
        else $error("result strobe without a matching request");
`endif

endmodule

### sv/abl_prep.sv
// stage one: alpha scaling, destination premultiply and mode decode
module abl_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_mode,
    input  logic [7:0]    i_galpha,
    input  logic [31:0]   i_src,
    input  logic [31:0]   i_dst,
    output abl_pkg::t_prep o_s
);
    import abl_pkg::*;

    logic [7:0]  src_a;
    logic [7:0]  dst_a;
    logic [8:0]  ga_inc;
    logic [15:0] sa_prod;
    logic [7:0]  sa_scaled;
    logic [8:0]  sa_inc;
    logic [8:0]  da;
    logic [15:0] dg;
    logic [23:0] dst_rb;
    logic [32:0] drb_prod;
    logic [8:0]  add_a;
    t_prep       n_s;
    t_prep       r_s;

    // operand math shared by the modes
    always_comb begin
        src_a     = i_src[31:24];
        dst_a     = i_dst[31:24];
        ga_inc    = {1'b0, i_galpha} + 9'd1;
        sa_prod   = 16'({8'h00, src_a} * {7'h00, ga_inc});
        sa_scaled = (i_galpha != 8'd0) ? sa_prod[15:8] : src_a;
        sa_inc    = {1'b0, sa_scaled} + 9'd1;
        da        = (dst_a == 8'd0) ? 9'd0 : ({1'b0, dst_a} + 9'd1);
        dg        = 16'({8'h00, i_dst[15:8]} * {7'h00, da});
        dst_rb    = i_dst[23:0] & MASK_RB24;
        drb_prod  = {9'h000, dst_rb} * {24'h00_0000, da};
        add_a     = {1'b0, src_a} + {1'b0, dst_a};
    end

    // mode decode
    always_comb begin
        n_s.valid   = i_start;
        n_s.kind    = K_PASS;
        n_s.pass    = i_dst;
        n_s.src_r   = i_src[23:16];
        n_s.src_g   = i_src[15:8];
        n_s.src_b   = i_src[7:0];
        n_s.base_rb = drb_prod[31:8];
        n_s.base_g  = dg;
        n_s.f       = sa_inc;
        n_s.da      = da;
        n_s.dst_a   = dst_a;
        unique case (i_mode)
            MODE_ARGB_OVER_ARGB: begin
                // transparent source leaves the destination as it is
                if (sa_scaled != 8'd0) begin
                    n_s.kind = K_OVER;
                end
            end
            MODE_RGB_OVER_ARGB: begin
                if (i_galpha == 8'd0 || i_galpha == 8'hFF) begin
                    n_s.pass = i_src | MASK_A;
                end else begin
                    n_s.kind = K_OVER;
                    n_s.f    = ga_inc;
                end
            end
            MODE_ARGB_OVER_RGB: begin
                n_s.kind    = K_LERP_NO_A;
                n_s.f       = (sa_scaled != 8'd0) ? sa_inc : 9'd0;
                n_s.base_rb = i_dst[23:0];
                n_s.base_g  = {i_dst[15:8], 8'h00};
            end
            MODE_TRANS_KEEP: begin
                n_s.kind    = K_LERP_KEEP_A;
                n_s.f       = (i_galpha != 8'd0) ? ga_inc : 9'd0;
                n_s.base_rb = i_dst[23:0];
                n_s.base_g  = {i_dst[15:8], 8'h00};
            end
            MODE_ADD_ALPHA: begin
                // summed alpha saturates
                n_s.pass = {(add_a[8] ? 8'hFF : add_a[7:0]), i_src[23:0]};
            end
            default: begin
                n_s.pass = i_dst;
            end
        endcase
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

### sv/abl_mix.sv
// stage two: per-channel blend toward the source and combined alpha
module abl_mix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  abl_pkg::t_prep i_s,
    output abl_pkg::t_mix  o_s
);
    import abl_pkg::*;

    logic [31:0] diff_rb;
    logic [31:0] diff_g;
    logic [40:0] prod_rb;
    logic [40:0] prod_g;
    logic [23:0] sum_rb;
    logic [15:0] sum_g;
    logic [8:0]  inv_f;
    logic [8:0]  inv_da;
    logic [17:0] fa_prod;
    logic [9:0]  fa_full;
    t_mix        n_s;
    t_mix        r_s;

    // 32-bit wrapping difference, scale by factor, add base back
    always_comb begin
        diff_rb = {8'h00, i_s.src_r, 8'h00, i_s.src_b} - {8'h00, i_s.base_rb & MASK_RB24};
        diff_g  = {16'h0000, i_s.src_g, 8'h00} - {16'h0000, i_s.base_g & MASK_G16};
        prod_rb = {9'h000, diff_rb} * {32'h0000_0000, i_s.f};
        prod_g  = {9'h000, diff_g} * {32'h0000_0000, i_s.f};
        sum_rb  = prod_rb[31:8] + i_s.base_rb;
        sum_g   = prod_g[23:8] + i_s.base_g;
    end

    // combined alpha of source over destination
    always_comb begin
        inv_f   = 9'd256 - i_s.f;
        inv_da  = 9'd256 - i_s.da;
        fa_prod = {9'h000, inv_f} * {9'h000, inv_da};
        fa_full = 10'd256 - fa_prod[17:8];
    end

    always_comb begin
        n_s.valid = i_s.valid;
        n_s.kind  = i_s.kind;
        n_s.pass  = i_s.pass;
        n_s.r     = sum_rb[23:16];
        n_s.g     = sum_g[15:8];
        n_s.b     = sum_rb[7:0];
        n_s.fa    = fa_full[8:0];
        n_s.dst_a = i_s.dst_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

### sv/abl_recip.sv
// stage three: reciprocal of the combined alpha from a constant table
module abl_recip (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  abl_pkg::t_mix i_s,
    output abl_pkg::t_rcp o_s
);
    import abl_pkg::*;

    logic [RECIP_W-1:0] rc_tab [RECIP_DEPTH];
    logic [7:0]         idx;
    t_rcp               n_s;
    t_rcp               r_s;

    // table contents fixed at elaboration
    for (genvar k = 0; k < RECIP_DEPTH; k++) begin : g_rc
        localparam int RC = RECIP_NUM / (k + 1);
        assign rc_tab[k] = RECIP_W'(RC);
    end

    // combined alpha runs 2..256, the table is indexed by alpha minus one
    always_comb begin
        idx       = 8'(i_s.fa - 9'd1);
        n_s.m     = i_s;
        n_s.recip = rc_tab[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

`ifndef ASSERT_OFF
    a_fa_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s.valid && i_s.kind == K_OVER) |-> (i_s.fa >= 9'd2 && i_s.fa <= 9'd256))
        else $error("combined alpha out of range for over blend");
`endif

endmodule

### sv/abl_norm.sv
// stage four: renormalize by the reciprocal and assemble the result pixel
module abl_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  abl_pkg::t_rcp i_s,
    output logic          o_strobe,
    output logic [31:0]   o_result_pixel
);
    import abl_pkg::*;

    logic [32:0] prod_g;
    logic [40:0] prod_rb;
    logic [7:0]  alpha;
    logic [31:0] n_result;
    logic        r_strobe;
    logic [31:0] r_result;

    // color times reciprocal, kept to 32 bits
    always_comb begin
        prod_g  = {1'b0, 16'({i_s.m.g, 8'h00}), 16'h0000} >> 16;
        prod_g  = {17'h0_0000, i_s.m.g, 8'h00} * {16'h0000, i_s.recip};
        prod_rb = {17'h0_0000, i_s.m.r, 8'h00, i_s.m.b} * {24'h00_0000, i_s.recip};
        alpha   = 8'(i_s.m.fa - 9'd1);
    end

    // result word by kind
    always_comb begin
        n_result = i_s.m.pass;
        case (i_s.m.kind)
            K_PASS:        n_result = i_s.m.pass;
            K_OVER:        n_result = {alpha, prod_rb[31:24], prod_g[23:16], prod_rb[15:8]};
            K_LERP_NO_A:   n_result = {8'h00, i_s.m.r, i_s.m.g, i_s.m.b};
            K_LERP_KEEP_A: n_result = {i_s.m.dst_a, i_s.m.r, i_s.m.g, i_s.m.b};
            default:       n_result = i_s.m.pass;
        endcase
    end

    // output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_s.m.valid;
        end
    end

    // output data
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe       = r_strobe;
    assign o_result_pixel = r_result;

endmodule
